/* design/rid_pkg.sv */
package rid_pkg;

   // Major opcodes that lead to a sub-table
   localparam logic [5:0] OP_SPECIAL  = 6'd0;
   localparam logic [5:0] OP_REGIMM   = 6'd1;
   localparam logic [5:0] OP_COP0     = 6'd16;
   localparam logic [5:0] OP_SPECIAL2 = 6'd28;

   typedef enum logic [1:0] {
      ST_VALID    = 2'd0,
      ST_RESERVED = 2'd1,
      ST_NYI      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      TB_MAIN      = 3'd0,
      TB_SPECIAL   = 3'd1,
      TB_REGIMM    = 3'd2,
      TB_SPECIAL2  = 3'd3,
      TB_COP0_MOVE = 3'd4,
      TB_COP0_CO   = 3'd5
   } table_type;

   typedef struct packed {
      status_type status;
      table_type  sel;
      logic [5:0] idx;
   } decode_type;

   function automatic logic in_span(logic [5:0] v, logic [5:0] lo, logic [5:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic logic reserved_main(logic [5:0] op);
      return in_span(op, 6'd17, 6'd19) || in_span(op, 6'd24, 6'd27) ||
             in_span(op, 6'd29, 6'd31) || in_span(op, 6'd39, 6'd39) ||
             in_span(op, 6'd44, 6'd45) || in_span(op, 6'd50, 6'd50) ||
             in_span(op, 6'd52, 6'd52) || in_span(op, 6'd54, 6'd55) ||
             in_span(op, 6'd58, 6'd60) || in_span(op, 6'd62, 6'd63);
   endfunction

   function automatic logic nyi_special(logic [5:0] fn);
      return in_span(fn, 6'd5, 6'd5)   || in_span(fn, 6'd14, 6'd14) ||
             in_span(fn, 6'd20, 6'd23) || in_span(fn, 6'd28, 6'd31) ||
             in_span(fn, 6'd40, 6'd41) || in_span(fn, 6'd44, 6'd47) ||
             in_span(fn, 6'd53, 6'd53) || in_span(fn, 6'd55, 6'd63);
   endfunction

   function automatic logic nyi_regimm(logic [5:0] rt);
      return in_span(rt, 6'd4, 6'd7)   || in_span(rt, 6'd13, 6'd13) ||
             in_span(rt, 6'd15, 6'd15) || in_span(rt, 6'd20, 6'd31);
   endfunction

   function automatic logic nyi_special2(logic [5:0] fn);
      return in_span(fn, 6'd3, 6'd3)   || in_span(fn, 6'd6, 6'd31) ||
             in_span(fn, 6'd34, 6'd62) || in_span(fn, 6'd63, 6'd63);
   endfunction

   function automatic logic nyi_cop0_co(logic [5:0] fn);
      return in_span(fn, 6'd0, 6'd23) || in_span(fn, 6'd25, 6'd31) ||
             in_span(fn, 6'd33, 6'd63);
   endfunction

   function automatic logic nyi_cop0_move(logic [5:0] rs);
      return in_span(rs, 6'd1, 6'd3) || in_span(rs, 6'd5, 6'd15);
   endfunction

endpackage

/* design/risc_instruction_decoder.sv */
// Instruction word decoder. Each accepted 32-bit word yields one result item
// naming the dispatch table (main, SPECIAL, REGIMM, SPECIAL2, COP0 move or
// COP0 CO) and the entry inside it, a status (valid, reserved instruction,
// not implemented) and every sliced field of the word, raw and unextended.
// Reserved or not-implemented words report table 0, index 0. The block takes
// one item per clock while the request side is not stalled; a word passes the
// input register, the opcode/range decode, then the result register. A stall on
// the result side holds the result register and, only when the input
// register is also full, stalls the request side in the same cycle, so no
// bubble is lost when the stall releases.
module risc_instruction_decoder import rid_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_decode_status,
   output logic [2:0]  rsp_table_select,
   output logic [5:0]  rsp_table_index,
   output logic [5:0]  rsp_major_opcode,
   output logic [4:0]  rsp_src_reg,
   output logic [4:0]  rsp_tgt_reg,
   output logic [4:0]  rsp_dst_reg,
   output logic [4:0]  rsp_shift_amount,
   output logic [5:0]  rsp_func_code,
   output logic [15:0] rsp_imm_value,
   output logic [25:0] rsp_jump_target,
   output logic [2:0]  rsp_cop_select
);

   // Input register
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [31:0] in_word_ff;
   logic [31:0] in_word_in;

   // Result register
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [31:0] out_word_ff;
   logic [31:0] out_word_in;
   decode_type  out_result_ff;
   decode_type  out_result_in;

   decode_type  decoded;
   logic        out_advance;

   rid_decode u_decode (
      .word   (in_word_ff),
      .result (decoded)
   );

   // Result register may load when empty or when its item leaves this cycle
   assign out_advance = !out_valid_ff || !rsp_stall;
   // Stall the request side only when the input register cannot drain
   assign req_stall   = in_valid_ff && !out_advance;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_word_in    = in_word_ff;
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      out_result_in = out_result_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_word_in  = req_instr_word;
      end
      if (out_advance) begin
         out_valid_in  = in_valid_ff;
         out_word_in   = in_word_ff;
         out_result_in = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_word_ff    <= in_word_in;
      out_word_ff   <= out_word_in;
      out_result_ff <= out_result_in;
   end

   // Result ports: decode outcome plus raw slices of the held word
   assign rsp_valid         = out_valid_ff;
   assign rsp_decode_status = out_result_ff.status;
   assign rsp_table_select  = out_result_ff.sel;
   assign rsp_table_index   = out_result_ff.idx;
   assign rsp_major_opcode  = out_word_ff[31:26];
   assign rsp_src_reg       = out_word_ff[25:21];
   assign rsp_tgt_reg       = out_word_ff[20:16];
   assign rsp_dst_reg       = out_word_ff[15:11];
   assign rsp_shift_amount  = out_word_ff[10:6];
   assign rsp_func_code     = out_word_ff[5:0];
   assign rsp_imm_value     = out_word_ff[15:0];
   assign rsp_jump_target   = out_word_ff[25:0];
   assign rsp_cop_select    = out_word_ff[2:0];

endmodule

/* design/rid_decode.sv */
module rid_decode import rid_pkg::*; (
   input  logic [31:0] word,
   output decode_type  result
);

   logic [5:0] op;
   logic [5:0] fn;
   logic [5:0] rs;
   logic [5:0] rt;
   logic       nyi;

   assign op = word[31:26];
   assign fn = word[5:0];
   assign rs = {1'b0, word[25:21]};
   assign rt = {1'b0, word[20:16]};

   always_comb begin
      result.status = ST_VALID;
      result.sel    = TB_MAIN;
      result.idx    = op;
      nyi           = 1'b0;
      if (reserved_main(op)) begin
         result.status = ST_RESERVED;
      end else begin
         case (op)
            OP_SPECIAL: begin
               result.sel = TB_SPECIAL;
               result.idx = fn;
               nyi        = nyi_special(fn);
            end
            OP_REGIMM: begin
               result.sel = TB_REGIMM;
               result.idx = rt;
               nyi        = nyi_regimm(rt);
            end
            OP_SPECIAL2: begin
               result.sel = TB_SPECIAL2;
               result.idx = fn;
               nyi        = nyi_special2(fn);
            end
            OP_COP0: begin
               if (word[25]) begin
                  result.sel = TB_COP0_CO;
                  result.idx = fn;
                  nyi        = nyi_cop0_co(fn);
               end else begin
                  result.sel = TB_COP0_MOVE;
                  result.idx = rs;
                  nyi        = nyi_cop0_move(rs);
               end
            end
            default: begin
            end
         endcase
      end
      if (nyi) begin
         result.status = ST_NYI;
      end
      // Drop table and index for anything that does not dispatch
      if (result.status != ST_VALID) begin
         result.sel = TB_MAIN;
         result.idx = 6'd0;
      end
   end

endmodule

/* design/rid_checker.sv */
module rid_checker import rid_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_decode_status,
   input logic [2:0]  rsp_table_select,
   input logic [5:0]  rsp_table_index,
   input logic [5:0]  rsp_major_opcode,
   input logic [4:0]  rsp_src_reg,
   input logic [4:0]  rsp_tgt_reg,
   input logic [4:0]  rsp_dst_reg,
   input logic [4:0]  rsp_shift_amount,
   input logic [5:0]  rsp_func_code,
   input logic [15:0] rsp_imm_value,
   input logic [25:0] rsp_jump_target,
   input logic [2:0]  rsp_cop_select
);

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_decode_status) &&
         $stable(rsp_table_select) && $stable(rsp_table_index) &&
         $stable(rsp_jump_target) && $stable(rsp_major_opcode) &&
         $stable(rsp_src_reg) && $stable(rsp_tgt_reg) && $stable(rsp_dst_reg) &&
         $stable(rsp_shift_amount) && $stable(rsp_func_code) &&
         $stable(rsp_imm_value) && $stable(rsp_cop_select))
      else $error("stalled result item changed");

   // Rejected words never carry a table or index
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_decode_status != ST_VALID |->
         rsp_table_select == TB_MAIN && rsp_table_index == 6'd0)
      else $error("rejected item carries a table entry");

   // SPECIAL dispatch comes from opcode zero and indexes by funct
   a_special_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_decode_status == ST_VALID && rsp_table_select == TB_SPECIAL |->
         rsp_major_opcode == OP_SPECIAL && rsp_table_index == rsp_func_code)
      else $error("SPECIAL dispatch mismatch");

   // Sub-table opcodes are never reserved
   a_reserved_op: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_decode_status == ST_RESERVED |->
         rsp_major_opcode != OP_SPECIAL && rsp_major_opcode != OP_REGIMM &&
         rsp_major_opcode != OP_COP0 && rsp_major_opcode != OP_SPECIAL2)
      else $error("sub-table opcode flagged reserved");

   // Request stall only ever comes with result stall
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without result backpressure");

endmodule

bind risc_instruction_decoder rid_checker u_rid_checker (.*);

/* tb/tb_risc_instruction_decoder.sv */
module tb_risc_instruction_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import rid_pkg::*;

   // Idle cycles with no item moving on either channel before the run is
   // declared hung; this is a wide margin over the longest sender gap.
   localparam int WATCHDOG_LIMIT = 1000;
   // Settling time after the drain, covering the input and result registers.
   localparam int DRAIN_CYCLES   = 8;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_ITEMS   = 1650;
   localparam int STEADY_ITEMS   = 100;

   // Everything one decoded word produces, as the block should report it.
   typedef struct packed {
      status_type  status;
      table_type   tsel;
      logic [5:0]  tidx;
      logic [5:0]  opcode;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sa;
      logic [5:0]  fn;
      logic [15:0] imm;
      logic [25:0] target;
      logic [2:0]  csel;
   } decoded_word_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PATTERN
   } stall_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_instr_word;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_decode_status;
   logic [2:0]  rsp_table_select;
   logic [5:0]  rsp_table_index;
   logic [5:0]  rsp_major_opcode;
   logic [4:0]  rsp_src_reg;
   logic [4:0]  rsp_tgt_reg;
   logic [4:0]  rsp_dst_reg;
   logic [4:0]  rsp_shift_amount;
   logic [5:0]  rsp_func_code;
   logic [15:0] rsp_imm_value;
   logic [25:0] rsp_jump_target;
   logic [2:0]  rsp_cop_select;

   decoded_word_type pending_decodes[$];
   int             mismatches   = 0;
   int             idle_cycles  = 0;
   int             burst_left   = 0;
   bit             steady       = 1'b0;
   stall_mode_type stall_mode   = STALL_NONE;
   int             stall_left   = 0;
   logic [7:0]     stall_pattern = 8'h00;

   risc_instruction_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_instr_word    (req_instr_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_decode_status (rsp_decode_status),
      .rsp_table_select  (rsp_table_select),
      .rsp_table_index   (rsp_table_index),
      .rsp_major_opcode  (rsp_major_opcode),
      .rsp_src_reg       (rsp_src_reg),
      .rsp_tgt_reg       (rsp_tgt_reg),
      .rsp_dst_reg       (rsp_dst_reg),
      .rsp_shift_amount  (rsp_shift_amount),
      .rsp_func_code     (rsp_func_code),
      .rsp_imm_value     (rsp_imm_value),
      .rsp_jump_target   (rsp_jump_target),
      .rsp_cop_select    (rsp_cop_select)
   );

   // 8 ns period
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Decode predictor
   // ---------------------------------------------------------------------

   // Major opcodes the architecture leaves reserved.
   function automatic bit major_reserved(logic [5:0] op);
      case (op)
         17, 18, 19, 24, 25, 26, 27, 29, 30, 31, 39, 44, 45, 50, 52, 54, 55,
         58, 59, 60, 62, 63: return 1'b1;
         default:            return 1'b0;
      endcase
   endfunction

   // SPECIAL funct entries that have an execution routine.
   function automatic bit special_known(logic [5:0] fn);
      if (fn >= 6'd55)
         return 1'b0;
      case (fn)
         5, 14, 20, 21, 22, 23, 28, 29, 30, 31, 40, 41, 44, 45, 46, 47, 53:
                  return 1'b0;
         default: return 1'b1;
      endcase
   endfunction

   // REGIMM rt entries that have an execution routine.
   function automatic bit regimm_known(logic [4:0] rt);
      case (rt)
         0, 1, 2, 3, 8, 9, 10, 11, 12, 14, 16, 17, 18, 19: return 1'b1;
         default:                                          return 1'b0;
      endcase
   endfunction

   // SPECIAL2 holds only the multiply-accumulate group and the count ops.
   function automatic bit special2_known(logic [5:0] fn);
      case (fn)
         0, 1, 2, 4, 5, 32, 33: return 1'b1;
         default:               return 1'b0;
      endcase
   endfunction

   // COP0 CO group: only ERET and WAIT.
   function automatic bit cop0_co_known(logic [5:0] fn);
      return (fn == 6'd24) || (fn == 6'd32);
   endfunction

   // COP0 move group: MFC0, MTC0 and the whole upper half of rs.
   function automatic bit cop0_move_known(logic [4:0] rs);
      return (rs == 5'd0) || (rs == 5'd4) || rs[4];
   endfunction

   function automatic decoded_word_type decode_word(logic [31:0] w);
      decoded_word_type d;
      bit               known;
      d.opcode = w[31:26];
      d.rs     = w[25:21];
      d.rt     = w[20:16];
      d.rd     = w[15:11];
      d.sa     = w[10:6];
      d.fn     = w[5:0];
      d.imm    = w[15:0];
      d.target = w[25:0];
      d.csel   = w[2:0];
      d.status = ST_VALID;
      d.tsel   = TB_MAIN;
      d.tidx   = w[31:26];
      known    = 1'b1;
      if (major_reserved(d.opcode)) begin
         d.status = ST_RESERVED;
      end else begin
         case (d.opcode)
            OP_SPECIAL: begin
               d.tsel = TB_SPECIAL;
               d.tidx = d.fn;
               known  = special_known(d.fn);
            end
            OP_REGIMM: begin
               d.tsel = TB_REGIMM;
               d.tidx = {1'b0, d.rt};
               known  = regimm_known(d.rt);
            end
            OP_SPECIAL2: begin
               d.tsel = TB_SPECIAL2;
               d.tidx = d.fn;
               known  = special2_known(d.fn);
            end
            OP_COP0: begin
               // bit 25 splits the CO group from the register moves
               if (w[25]) begin
                  d.tsel = TB_COP0_CO;
                  d.tidx = d.fn;
                  known  = cop0_co_known(d.fn);
               end else begin
                  d.tsel = TB_COP0_MOVE;
                  d.tidx = {1'b0, d.rs};
                  known  = cop0_move_known(d.rs);
               end
            end
            default: ;
         endcase
      end
      if (!known)
         d.status = ST_NYI;
      // any rejected word reports table 0, entry 0
      if (d.status != ST_VALID) begin
         d.tsel = TB_MAIN;
         d.tidx = 6'd0;
      end
      return d;
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard and watchdog
   // ---------------------------------------------------------------------

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s expected %0h got %0h", $realtime, name, want, got);
      end
   endtask

   // Sample both channels on the clock edge, before any driver update lands.
   always @(posedge clock) begin : scoreboard
      decoded_word_type want;
      decoded_word_type got;
      bit               moved;
      moved = 1'b0;
      if (!reset) begin
         // predict every word the block takes in
         if (req_valid && !req_stall) begin
            pending_decodes.push_back(decode_word(req_instr_word));
            moved = 1'b1;
         end
         // match every result the block hands over against the oldest one
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (pending_decodes.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: result item with no word outstanding", $realtime);
            end else begin
               want = pending_decodes.pop_front();
               got.status = status_type'(rsp_decode_status);
               got.tsel   = table_type'(rsp_table_select);
               got.tidx   = rsp_table_index;
               got.opcode = rsp_major_opcode;
               got.rs     = rsp_src_reg;
               got.rt     = rsp_tgt_reg;
               got.rd     = rsp_dst_reg;
               got.sa     = rsp_shift_amount;
               got.fn     = rsp_func_code;
               got.imm    = rsp_imm_value;
               got.target = rsp_jump_target;
               got.csel   = rsp_cop_select;
               check_field("decode_status", 32'(want.status), 32'(got.status));
               check_field("table_select",  32'(want.tsel),   32'(got.tsel));
               check_field("table_index",   32'(want.tidx),   32'(got.tidx));
               check_field("major_opcode",  32'(want.opcode), 32'(got.opcode));
               check_field("src_reg",       32'(want.rs),     32'(got.rs));
               check_field("tgt_reg",       32'(want.rt),     32'(got.rt));
               check_field("dst_reg",       32'(want.rd),     32'(got.rd));
               check_field("shift_amount",  32'(want.sa),     32'(got.sa));
               check_field("func_code",     32'(want.fn),     32'(got.fn));
               check_field("imm_value",     32'(want.imm),    32'(got.imm));
               check_field("jump_target",   32'(want.target), 32'(got.target));
               check_field("cop_select",    32'(want.csel),   32'(got.csel));
            end
         end
         // nothing moved: advance the hang counter, abort once it runs out
         if (moved) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("SCOREBOARD MISMATCH");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall on a pattern of its own
   // ---------------------------------------------------------------------

   // Each stretch picks a mode: no stall at all, random stalls on 40 percent of
   // cycles, or a rotating 8-bit pattern. Bit 0 of the pattern is forced low so
   // the pattern mode always releases the receiver.
   always @(posedge clock) begin : receiver
      bit hold_off;
      if (stall_left == 0) begin
         stall_mode       = stall_mode_type'($urandom_range(0, 2));
         stall_left       = $urandom_range(16, 160);
         stall_pattern    = 8'($urandom_range(0, 255));
         stall_pattern[0] = 1'b0;
      end
      stall_left--;
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      case (stall_mode)
         STALL_RANDOM:  hold_off = ($urandom_range(0, 99) < 40);
         STALL_PATTERN: hold_off = stall_pattern[0];
         default:       hold_off = 1'b0;
      endcase
      rsp_stall <= hold_off && !steady && !reset;
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------

   // Offer one word and hold it until the block takes it. Outside steady
   // mode the sender works in bursts and drops valid for a random gap
   // between them; most gaps are short, some are long.
   task automatic push_word(input logic [31:0] w);
      int unsigned gap;
      if (!steady && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 7) == 0)
            gap = $urandom_range(6, 30);
         else
            gap = $urandom_range(0, 3);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left != 0)
         burst_left--;
      req_valid      <= 1'b1;
      req_instr_word <= w;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [31:0] r_word(logic [5:0] op, logic [4:0] rs,
                                          logic [4:0] rt, logic [15:0] low);
      return {op, rs, rt, low};
   endfunction

   // Random word, biased toward the sub-tables so each gets deep coverage;
   // the fully random share keeps every bit toggling in both directions.
   function automatic logic [31:0] random_word();
      logic [31:0] w;
      int unsigned pick;
      w    = $urandom;
      pick = $urandom_range(0, 11);
      case (pick)
         0, 1, 2: ;
         3: w[31:26] = OP_SPECIAL;
         4: w[31:26] = OP_REGIMM;
         5: w[31:26] = OP_SPECIAL2;
         6: begin
            w[31:26] = OP_SPECIAL2;
            w[5:0]   = 6'($urandom_range(0, 5));
         end
         7: w[31:26] = OP_COP0;
         8: begin
            // land on the few implemented CO entries
            w[31:25] = {OP_COP0, 1'b1};
            w[5:0]   = ($urandom_range(0, 1) == 0) ? 6'd24 : 6'd32;
         end
         9: begin
            w[31:25] = {OP_COP0, 1'b0};
            w[24:21] = $urandom_range(0, 1) ? 4'd4 : 4'd0;
         end
         default: w[31:26] = 6'($urandom_range(2, 63));
      endcase
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // All-zero, all-one and alternating words push every field to its ends.
   task automatic test_field_extremes();
      push_word(32'h0000_0000);
      push_word(32'hFFFF_FFFF);
      push_word(32'hAAAA_AAAA);
      push_word(32'h5555_5555);
   endtask

   // Implemented entries from every dispatch table, plus one unimplemented COP0 CO word.
   task automatic test_each_table();
      push_word({OP_SPECIAL, 5'd3, 5'd4, 5'd5, 5'd0, 6'd32});
      push_word(r_word(OP_REGIMM, 5'd9, 5'd17, 16'h8001));
      push_word({OP_SPECIAL2, 5'd7, 5'd8, 5'd9, 5'd0, 6'd2});
      push_word({OP_COP0, 5'd4, 5'd12, 5'd14, 8'd0, 3'd7});
      push_word({OP_COP0, 1'b1, 19'd0, 6'd24});
      push_word({OP_COP0, 5'd31, 5'd1, 5'd2, 8'd0, 3'd0});
      push_word(r_word(6'd35, 5'd29, 5'd2, 16'hFFFC));
      push_word({6'd2, 26'h3FF_FFFF});
   endtask

   // Reserved opcodes and unimplemented entries at the edges of holes in each table.
   task automatic test_rejected_codes();
      push_word(r_word(6'd17, 5'd1, 5'd2, 16'h1234));
      push_word(r_word(6'd39, 5'd31, 5'd0, 16'hFFFF));
      push_word({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd4, 6'd5});
      push_word({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd4, 6'd55});
      push_word({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd4, 6'd63});
      push_word(r_word(OP_REGIMM, 5'd0, 5'd4, 16'h0000));
      push_word(r_word(OP_REGIMM, 5'd0, 5'd31, 16'h7FFF));
      push_word({OP_SPECIAL2, 5'd0, 5'd0, 5'd0, 5'd0, 6'd3});
      push_word({OP_SPECIAL2, 5'd0, 5'd0, 5'd0, 5'd0, 6'd63});
      push_word({OP_COP0, 1'b1, 19'd0, 6'd0});
      push_word({OP_COP0, 1'b1, 19'h7FFFF, 6'd63});
      push_word({OP_COP0, 5'd1, 5'd3, 5'd9, 8'd0, 3'd5});
      push_word({OP_COP0, 5'd15, 5'd3, 5'd9, 8'd0, 3'd2});
   endtask

   // Back-to-back words with the receiver never stalling: full rate.
   task automatic test_full_rate();
      steady = 1'b1;
      repeat (STEADY_ITEMS) push_word(random_word());
      steady = 1'b0;
   endtask

   // Bulk random words under bursty sending and receiver stalls.
   task automatic test_random_words();
      repeat (RANDOM_ITEMS) push_word(random_word());
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_instr_word = 32'h0;
      rsp_stall      = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_each_table();
      test_rejected_codes();
      test_full_rate();
      test_random_words();

      // drop valid, drain what is still in flight, then let the pipe settle
      req_valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
design/rid_pkg.sv
design/rid_decode.sv
design/risc_instruction_decoder.sv
design/rid_checker.sv
tb/tb_risc_instruction_decoder.sv
